@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers used by the sorted list engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold on every edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ rtl/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// sle_pkg
// Types, constants and helpers of the sorted list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY = 32;
  localparam int VALUE_W  = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FIELD_W  = 32;
  localparam int ECNT_W   = 6;

  typedef logic signed [VALUE_W-1:0] val_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [ADDR_W-1:0]         addr_t;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_POP    = 3'd1,
    CMD_DEDUPE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_DUMP   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_POP_HEAD,
    S_POP_RD,
    S_POP_WR,
    S_POP_END,
    S_DED_HEAD,
    S_DED_RD,
    S_DED_CMP,
    S_DED_END,
    S_DMP_RD,
    S_DMP_OUT,
    S_RESP
  } state_t;

  // One result beat handed from the sequencer to the output register.
  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               valid_flag;
    logic               last;
    logic [ECNT_W-1:0]  count;
    status_t            status;
  } beat_t;

  // 32-bit input field to stored width (sign extend or truncate).
  function automatic val_t to_store(logic signed [FIELD_W-1:0] x);
    return val_t'(x);
  endfunction

  // Stored value to 32-bit output field.
  function automatic logic [FIELD_W-1:0] to_field(val_t v);
    logic signed [FIELD_W-1:0] r;
    r = FIELD_W'(v);
    return r;
  endfunction

  // Count reported modulo 64.
  function automatic logic [ECNT_W-1:0] cnt_field(cnt_t c);
    logic [CNT_W+ECNT_W-1:0] w;
    w = {{ECNT_W{1'b0}}, c};
    return w[ECNT_W-1:0];
  endfunction

endpackage

@@ rtl/sle_ram.sv @@
// ----------------------------------------------------------------------------
// sle_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/sle_cmp.sv @@
// ----------------------------------------------------------------------------
// sle_cmp
// Shared signed compare unit: ordering for insert, equality for dedupe.
// ----------------------------------------------------------------------------
module sle_cmp
  import sle_pkg::*;
(
  input  val_t a,
  input  val_t b,
  output logic ge,
  output logic eq
);

  assign ge = (a >= b);
  assign eq = (a == b);

endmodule

@@ rtl/sle_ctrl.sv @@
// ----------------------------------------------------------------------------
// sle_ctrl
// Command sequencer: walks the entry RAM one element per step using the
// shared compare unit, and emits result beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sle_ctrl
  import sle_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_cmd,
  input  logic [FIELD_W-1:0]  in_value,
  input  logic                slot_free,
  output logic                emit,
  output beat_t               beat
);

  state_t  state_r, state_nxt;
  cnt_t    cnt_r, cnt_nxt;
  cnt_t    idx_r, idx_nxt;
  cnt_t    kept_r, kept_nxt;
  val_t    val_r, val_nxt;
  logic    rvalid_r, rvalid_nxt;
  status_t status_r, status_nxt;

  logic    rd_en, wr_en;
  addr_t   rd_addr, wr_addr;
  val_t    wr_data, rd_data;
  logic    cmp_ge, cmp_eq;
  logic    accept;
  cnt_t    idx_m1;
  logic    idx_at_end;

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign idx_m1     = idx_r - cnt_t'(1);
  assign idx_at_end = ((idx_r + cnt_t'(1)) == cnt_r);

  sle_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sle_cmp u_cmp (
    .a  (rd_data),
    .b  (val_r),
    .ge (cmp_ge),
    .eq (cmp_eq)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_cmd))
            CMD_INSERT: begin
              if (cnt_r == cnt_t'(CAPACITY)) state_nxt = S_RESP;
              else if (cnt_r == '0)          state_nxt = S_INS_PUT;
              else                           state_nxt = S_INS_RD;
            end
            CMD_POP:    state_nxt = (cnt_r == '0) ? S_RESP : S_POP_HEAD;
            CMD_DEDUPE: state_nxt = (cnt_r > cnt_t'(1)) ? S_DED_HEAD : S_RESP;
            CMD_CLEAR:  state_nxt = S_RESP;
            CMD_DUMP:   state_nxt = (cnt_r == '0) ? S_RESP : S_DMP_RD;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_RD:   state_nxt = S_INS_CMP;
      S_INS_CMP: begin
        if (cmp_ge && idx_m1 != '0) state_nxt = S_INS_RD;
        else                        state_nxt = S_INS_PUT;
      end
      S_INS_PUT:  state_nxt = S_RESP;
      S_POP_HEAD: state_nxt = (cnt_r == cnt_t'(1)) ? S_POP_END : S_POP_RD;
      S_POP_RD:   state_nxt = S_POP_WR;
      S_POP_WR:   state_nxt = idx_at_end ? S_POP_END : S_POP_RD;
      S_POP_END:  state_nxt = S_RESP;
      S_DED_HEAD: state_nxt = S_DED_RD;
      S_DED_RD:   state_nxt = S_DED_CMP;
      S_DED_CMP:  state_nxt = idx_at_end ? S_DED_END : S_DED_RD;
      S_DED_END:  state_nxt = S_RESP;
      S_DMP_RD:   state_nxt = S_DMP_OUT;
      S_DMP_OUT: begin
        if (slot_free) state_nxt = idx_at_end ? S_IDLE : S_DMP_RD;
      end
      S_RESP: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // RAM port control and result beats
  always_comb begin
    rd_en            = 1'b0;
    rd_addr          = '0;
    wr_en            = 1'b0;
    wr_addr          = idx_r[ADDR_W-1:0];
    wr_data          = val_r;
    emit             = 1'b0;
    beat.value       = '0;
    beat.valid_flag  = 1'b0;
    beat.last        = 1'b1;
    beat.count       = cnt_field(cnt_r);
    beat.status      = status_r;
    case (state_r)
      S_IDLE: begin
        // pop and dedupe both start at the head
        if (accept && ((cmd_t'(in_cmd) == CMD_POP && cnt_r != '0) ||
                       (cmd_t'(in_cmd) == CMD_DEDUPE && cnt_r > cnt_t'(1)))) begin
          rd_en = 1'b1;
        end
      end
      S_INS_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_m1[ADDR_W-1:0];
      end
      S_INS_CMP: begin
        // entry not below the new value moves up one place
        wr_en   = cmp_ge;
        wr_data = rd_data;
      end
      S_INS_PUT: begin
        wr_en = 1'b1;
      end
      S_POP_RD, S_DED_RD, S_DMP_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_r[ADDR_W-1:0];
      end
      S_POP_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_m1[ADDR_W-1:0];
        wr_data = rd_data;
      end
      S_DED_CMP: begin
        wr_en   = !cmp_eq;
        wr_addr = kept_r[ADDR_W-1:0];
        wr_data = rd_data;
      end
      S_DMP_OUT: begin
        emit            = slot_free;
        beat.value      = to_field(rd_data);
        beat.valid_flag = 1'b1;
        beat.last       = idx_at_end;
        beat.status     = ST_OK;
      end
      S_RESP: begin
        emit            = slot_free;
        beat.value      = rvalid_r ? to_field(val_r) : '0;
        beat.valid_flag = rvalid_r;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // datapath registers
  always_comb begin
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    kept_nxt   = kept_r;
    val_nxt    = val_r;
    rvalid_nxt = rvalid_r;
    status_nxt = status_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt    = to_store(in_value);
          rvalid_nxt = 1'b0;
          status_nxt = ST_OK;
          idx_nxt    = '0;
          case (cmd_t'(in_cmd))
            CMD_INSERT: begin
              idx_nxt = cnt_r;
              if (cnt_r == cnt_t'(CAPACITY)) status_nxt = ST_FULL;
            end
            CMD_POP:    if (cnt_r == '0) status_nxt = ST_EMPTY;
            CMD_DUMP:   if (cnt_r == '0) status_nxt = ST_EMPTY;
            CMD_CLEAR:  cnt_nxt = '0;
            default:    status_nxt = ST_OK;
          endcase
        end
      end
      S_INS_CMP: begin
        if (cmp_ge) idx_nxt = idx_m1;
      end
      S_INS_PUT:  cnt_nxt = cnt_r + cnt_t'(1);
      S_POP_HEAD: begin
        val_nxt    = rd_data;
        rvalid_nxt = 1'b1;
        idx_nxt    = cnt_t'(1);
      end
      S_POP_WR:   idx_nxt = idx_r + cnt_t'(1);
      S_POP_END:  cnt_nxt = cnt_r - cnt_t'(1);
      S_DED_HEAD: begin
        val_nxt  = rd_data;
        kept_nxt = cnt_t'(1);
        idx_nxt  = cnt_t'(1);
      end
      S_DED_CMP: begin
        idx_nxt = idx_r + cnt_t'(1);
        if (!cmp_eq) begin
          kept_nxt = kept_r + cnt_t'(1);
          val_nxt  = rd_data;
        end
      end
      S_DED_END:  cnt_nxt = kept_r;
      S_DMP_OUT: begin
        if (slot_free && !idx_at_end) idx_nxt = idx_r + cnt_t'(1);
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      idx_r    <= '0;
      kept_r   <= '0;
      rvalid_r <= 1'b0;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      kept_r   <= kept_nxt;
      rvalid_r <= rvalid_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  `ASSERT_NEVER(a_cnt_bound, clk, rst_n, cnt_r > cnt_t'(CAPACITY))
  `ASSERT_NEVER(a_emit_slot, clk, rst_n, emit && !slot_free)
  `ASSERT_PROP(a_idle_quiet, clk, rst_n, (state_r == S_IDLE) |-> !emit)
  `ASSERT_PROP(a_pop_empty, clk, rst_n, (accept && cmd_t'(in_cmd) == CMD_POP && cnt_r == '0) |=> (state_r == S_RESP && status_r == ST_EMPTY))

endmodule

@@ rtl/sorted_list_engine.sv @@
// ----------------------------------------------------------------------------
// sorted_list_engine
// Bounded ascending store of signed values (sorted-insertion priority queue).
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a command in in_tuser and a value in in_tdata. Insert
//   places the value in order (dropped with status FULL when the store holds
//   CAPACITY entries), pop returns the smallest entry, dedupe keeps the first
//   of each run of equal entries, clear empties the store and dump returns
//   every entry lowest first. Unused command codes are taken and ignored.
//   Every command but dump yields one beat; dump yields one beat per entry,
//   with out_tlast on the final one. Pop or dump on an empty store yields one
//   beat with result_valid low and status EMPTY.
// Timing: in_tready stays low while a command runs. Insert walks the entries
//   it compares, pop and dedupe walk the whole store and dump every entry;
//   clear, full insert, empty pop or dump and dedupe of at most one entry
//   walk none. The single entry RAM sets the pace: one read or write step per
//   element, registered read first.
// The result beat sits in an output register; the sequencer stalls while the
//   receiver holds out_tready low and that register is full.
// Reset (rst_n low, synchronous) empties the store; RAM contents are not
//   cleared, as entries at or above the count are never read.
// ----------------------------------------------------------------------------
module sorted_list_engine
  import sle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] cmd
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] result_value, [37:32] entry_count, [39:38] zero
  output logic [2:0]  out_tuser,  // [0] result_valid, [2:1] status
  output logic        out_tlast   // last
);

  logic  out_valid_r;
  beat_t out_beat_r;
  logic  slot_free;
  logic  emit;
  beat_t beat;

  // output register can take a beat when empty or draining this cycle
  assign slot_free = !out_valid_r || out_tready;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_value  (in_tdata),
    .slot_free (slot_free),
    .emit      (emit),
    .beat      (beat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (emit) begin
      out_beat_r <= beat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_beat_r.count, out_beat_r.value};
  assign out_tuser  = {out_beat_r.status, out_beat_r.valid_flag};
  assign out_tlast  = out_beat_r.last;

endmodule

@@ sim/sorted_list_checker.sv @@
// ----------------------------------------------------------------------------
// sorted_list_checker
// Watches both streams of the sorted list engine, keeps its own ordered copy
// of the store and compares every result beat with the predicted one.
// ----------------------------------------------------------------------------
module sorted_list_checker
  import sle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic [31:0] value;
    logic        valid;
    logic        last;
    logic [5:0]  count;
    status_t     status;
  } reply_t;

  val_t   ordered_vals[$];
  reply_t pending_replies[$];

  // count is taken after the command has changed the store
  function automatic reply_t make_reply(logic [31:0] v, logic ok, logic fin,
                                        status_t st);
    reply_t r;
    r.value  = v;
    r.valid  = ok;
    r.last   = fin;
    r.count  = 6'(ordered_vals.size());
    r.status = st;
    return r;
  endfunction

  // append to the tail of the expected queue
  task automatic queue_reply(reply_t r);
    pending_replies.insert(pending_replies.size(), r);
  endtask

  task automatic apply_command(logic [2:0] code, logic [31:0] data);
    val_t v;
    val_t kept[$];
    int   pos;
    case (code)
      CMD_INSERT: begin
        if (ordered_vals.size() >= CAPACITY) begin
          queue_reply(make_reply('0, 1'b0, 1'b1, ST_FULL));
        end else begin
          v   = val_t'($signed(data));
          pos = 0;
          // goes ahead of the first entry >= v
          while (pos < ordered_vals.size() && ordered_vals[pos] < v) pos++;
          ordered_vals.insert(pos, v);
          queue_reply(make_reply('0, 1'b0, 1'b1, ST_OK));
        end
      end
      CMD_POP: begin
        if (ordered_vals.size() == 0) begin
          queue_reply(make_reply('0, 1'b0, 1'b1, ST_EMPTY));
        end else begin
          v = ordered_vals[0];
          ordered_vals.delete(0);
          queue_reply(make_reply(32'(v), 1'b1, 1'b1, ST_OK));
        end
      end
      CMD_DEDUPE: begin
        // store is sorted, so equal entries sit next to each other
        foreach (ordered_vals[i])
          if (kept.size() == 0 || kept[$] != ordered_vals[i])
            kept.insert(kept.size(), ordered_vals[i]);
        ordered_vals = kept;
        queue_reply(make_reply('0, 1'b0, 1'b1, ST_OK));
      end
      CMD_CLEAR: begin
        ordered_vals.delete();
        queue_reply(make_reply('0, 1'b0, 1'b1, ST_OK));
      end
      CMD_DUMP: begin
        if (ordered_vals.size() == 0) begin
          queue_reply(make_reply('0, 1'b0, 1'b1, ST_EMPTY));
        end else begin
          foreach (ordered_vals[i])
            queue_reply(make_reply(32'(ordered_vals[i]), 1'b1,
                                   i == ordered_vals.size() - 1, ST_OK));
        end
      end
      default: ; // spare codes: no beat, no change
    endcase
  endtask

  task automatic check_beat();
    reply_t want;
    if (pending_replies.size() == 0) begin
      $error("result beat with nothing expected: tdata %h tuser %b", out_tdata, out_tuser);
      fail_count++;
    end else begin
      want = pending_replies[0];
      pending_replies.delete(0);
      if (out_tdata[31:0] !== want.value) begin
        $error("result_value: expected %0d, got %0d",
               $signed(want.value), $signed(out_tdata[31:0]));
        fail_count++;
      end
      if (out_tuser[0] !== want.valid) begin
        $error("result_valid: expected %0d, got %0d", want.valid, out_tuser[0]);
        fail_count++;
      end
      if (out_tlast !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, out_tlast);
        fail_count++;
      end
      if (out_tdata[37:32] !== want.count) begin
        $error("entry_count: expected %0d, got %0d", want.count, out_tdata[37:32]);
        fail_count++;
      end
      if (out_tuser[2:1] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_tuser[2:1]);
        fail_count++;
      end
    end
  endtask

  // result first: a beat leaving on the same edge belongs to an older command
  always @(posedge clk) begin
    if (!rst_n) begin
      ordered_vals.delete();
      pending_replies.delete();
    end else begin
      if (out_tvalid && out_tready) check_beat();
      if (in_tvalid && in_tready) apply_command(in_tuser, in_tdata);
    end
    outstanding = pending_replies.size();
  end

endmodule

@@ sim/sorted_list_engine_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_list_engine_tb
// Drives command beats into the sorted list engine under random bursts and
// result-side stalls; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module sorted_list_engine_tb;
  import sle_pkg::*;

  // codes the block must take and ignore
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS  = 500;
  localparam int IDLE_LIMIT    = 2000;  // cycles without any beat
  localparam int SETTLE_CYCLES = 200;   // longer than a full dedupe or insert

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value
  logic [2:0]  in_tuser;   // [2:0] cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] result_value, [37:32] entry_count, [39:38] zero
  logic [2:0]  out_tuser;  // [0] result_valid, [2:1] status
  logic        out_tlast;

  int   fail_count;
  int   outstanding;
  int   idle_cycles;
  logic in_taken;
  int   burst_left;

  sorted_list_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sorted_list_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // input beat taken at the last rising edge; read by the driver at the next falling one
  always @(posedge clk) in_taken <= in_tvalid && in_tready;

  // watchdog: no beat on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sorted_list_engine_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: ready runs (now and then a long one) broken by short stalls
  initial begin
    int run;
    out_tready = 1'b0;
    forever begin
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      repeat (run) @(negedge clk) out_tready = 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk) out_tready = 1'b0;
    end
  end

  // one command beat; opens a new burst after a random gap when the last one ran out
  task automatic send_command(logic [2:0] code, logic [31:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser  = code;
    in_tdata  = data;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic hold_until_drained();
    if (outstanding != 0) begin
      in_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clk);
    end
  endtask

  // full range, a narrow band that makes duplicates, or an extreme
  function automatic logic [31:0] rand_value();
    int k;
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: begin
        k = $urandom_range(0, 10);
        return 32'(k - 5);
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  function automatic logic [2:0] pick_cmd(int ins_pct, int pop_pct);
    int r;
    int s;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 9);
    if (r < ins_pct) return CMD_INSERT;
    if (r < ins_pct + pop_pct) return CMD_POP;
    if (s == 0) return CMD_CLEAR;
    if (s < 4) return CMD_DEDUPE;
    return CMD_DUMP;
  endfunction

  initial begin
    int issued;
    int kind;
    int len;
    int ins_pct;
    int pop_pct;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_INSERT;
    burst_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: empty-store cases, extremes, duplicates, spare codes
    send_command(CMD_POP,    32'h0);
    send_command(CMD_DUMP,   32'h0);
    send_command(CMD_DEDUPE, 32'h0);
    send_command(CMD_INSERT, 32'h7fff_ffff);
    send_command(CMD_INSERT, 32'h8000_0000);
    send_command(CMD_INSERT, 32'h0000_0000);
    send_command(CMD_INSERT, 32'hffff_ffff);
    send_command(CMD_INSERT, 32'h0000_0001);
    send_command(CMD_INSERT, 32'h0000_0000);
    send_command(CMD_INSERT, 32'h0000_0000);
    send_command(CMD_INSERT, 32'h8000_0000);
    send_command(CMD_DUMP,   32'h0);
    send_command(CMD_DEDUPE, 32'h0);
    send_command(CMD_DUMP,   32'h0);
    send_command(CMD_POP,    32'h0);
    send_command(CMD_POP,    32'h0);
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) send_command(3'(c), 32'hffff_ffff);
    send_command(CMD_CLEAR,  32'h0);
    send_command(CMD_DUMP,   32'h0);
    send_command(CMD_INSERT, 32'h5a5a_a5a5);
    send_command(CMD_POP,    32'h0);
    hold_until_drained();

    // random: grow, drain and mixed runs, plus the odd fill to capacity
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) hold_until_drained();
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        send_command(CMD_CLEAR, rand_value());
        repeat (CAPACITY + 3) send_command(CMD_INSERT, rand_value());
        send_command(CMD_DUMP, rand_value());
        send_command(CMD_DEDUPE, rand_value());
        send_command(CMD_DUMP, rand_value());
        issued += CAPACITY + 7;
      end else begin
        len     = $urandom_range(8, 40);
        ins_pct = (kind < 5) ? 80 : (kind < 7) ? 15 : 30;
        pop_pct = (kind < 5) ? 8  : (kind < 7) ? 65 : 25;
        repeat (len) begin
          if (kind >= 7 && $urandom_range(0, 15) == 0) begin
            send_command(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), $urandom);
          end else begin
            send_command(pick_cmd(ins_pct, pop_pct), rand_value());
            issued++;
          end
        end
      end
    end

    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("sorted_list_engine_tb: clean");
    end else begin
      $display("sorted_list_engine_tb: errors");
    end
    $finish;
  end

endmodule
